// ===== sv/otlp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the offset table with linear probing.
// Used by the channel payloads, the controller, the datapath and the modulo unit.
package otlp_pkg;

    localparam int KEY_W    = 32;
    localparam int ORD_W    = 8;
    localparam int TAG_W    = 64;
    localparam int EXT_W    = 24;
    localparam int ADDR_W   = 64;
    localparam int OFF_W    = 32;
    localparam int STAT_W   = 3;
    localparam int PRB_W    = 9;
    localparam int TOT_W    = 31;
    localparam int SRCH_W   = 9;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;

    // Configuration register widths
    localparam int SHIFT_W  = 4;
    localparam int SLOTS_W  = 5;
    localparam int BASE_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Slot counts and probe counts never exceed the slots_in_use range
    localparam int CNT_W    = SLOTS_W;
    localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd16;

    // Sum of running total, extension and base fits in one 32-bit word
    localparam int SUM_W    = 32;

    // Remainder unit: one 4-bit digit of the key per cycle
    localparam int MOD_DIGIT = 4;
    localparam int MOD_STEPS = KEY_W / MOD_DIGIT;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE      = 2'd3;

    // What the result carries besides status
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INS  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key_id;
        logic [ORD_W-1:0]  slot_order;
        logic [TAG_W-1:0]  type_tag;
        logic [EXT_W-1:0]  ext_size;
        logic [ADDR_W-1:0] obj_address;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [OFF_W-1:0] offset;
        logic [ADDR_W-1:0]       address;
        logic [PRB_W-1:0]        probes;
        logic [TOT_W-1:0]        total_size;
        logic [SRCH_W-1:0]       search_length;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  addr;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_item;

    typedef struct packed {
        logic              load;
        logic              mod_start;
        logic              pos_order;
        logic              pos_mod;
        logic              count;
        logic              advance;
        logic              read;
        logic              commit;
        logic              clear;
        logic              finish;
        logic [STAT_W-1:0] res_status;
        logic [KIND_W-1:0] res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hash_mode;
        logic            order_ok;
        logic            mod_done;
        logic            slot_free;
        logic            tag_match;
        logic            ins_last;
        logic            lk_last;
        logic            overflow;
        logic            out_free;
    } t_dp_sts;

endpackage

// ===== sv/otlp_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload item per handshake.
// The payload type comes from otlp_pkg at the point of instantiation.
interface otlp_chan_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/otlp_mod.sv =====
`timescale 1ns / 1ps
// Remainder unit: key mod slot count, restoring, one 4-bit digit per cycle.
// Depends on otlp_pkg for widths.
module otlp_mod import otlp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [KEY_W-1:0]   i_value,
    input  logic [CNT_W-1:0]   i_div,
    output logic               o_done,
    output logic [CNT_W-1:0]   o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0]     r_div;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     n_rem;

    always_comb begin
        logic [CNT_W:0]     t;
        logic [CNT_W-1:0]   rv;
        logic [MOD_DIGIT-1:0] dig;
        dig = r_div[KEY_W-1 -: MOD_DIGIT];
        rv = r_rem;
        for (int i = 0; i < MOD_DIGIT; i++) begin
            t = {rv, dig[MOD_DIGIT-1-i]};
            if (t >= {1'b0, i_div}) begin
                t = t - {1'b0, i_div};
            end
            rv = t[CNT_W-1:0];
        end
        n_rem = rv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_value;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_div <= r_div << MOD_DIGIT;
            r_rem <= n_rem;
            r_cnt <= r_cnt + MOD_CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== sv/otlp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, item registers, tag/offset memory,
// valid bits, running size, longest probe and the result register.
// Depends on otlp_pkg and otlp_mod; driven by otlp_ctrl commands.
module otlp_dp import otlp_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  t_cfg_item i_cfg,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [PRB_W-1:0] DEPTH_N = PRB_W'(TABLE_DEPTH);

    // Configuration
    logic               r_hash_mode;
    logic [SHIFT_W-1:0] r_id_shift;
    logic [SLOTS_W-1:0] r_slots;
    logic [BASE_W-1:0]  r_base;

    // Item under work
    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_key;
    logic [ORD_W-1:0]  r_order;
    logic [TAG_W-1:0]  r_tag;
    logic [ADDR_W-1:0] r_obj;
    logic [SUM_W-1:0]  r_new_total;

    // Table state
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TAG_W+OFF_W-1:0] mem [TABLE_DEPTH];
    logic [TAG_W+OFF_W-1:0] r_rd;
    logic                   r_rd_valid;
    logic [TOT_W-1:0]       r_size_total;
    logic [CNT_W-1:0]       r_max_probe;
    logic [IDX_W-1:0]       r_pos;
    logic [CNT_W-1:0]       r_probes;

    logic                   r_out_valid;
    t_out_item              r_out;

    logic [CNT_W-1:0]  slot_n;
    logic [CNT_W-1:0]  lk_limit;
    logic [SUM_W-1:0]  need_sum;
    logic [OFF_W-1:0]  ins_off;
    logic [OFF_W-1:0]  rd_off;
    logic [TOT_W-1:0]  n_size_total;
    logic [CNT_W-1:0]  n_max_probe;
    logic              mod_done;
    logic [CNT_W-1:0]  mod_rem;
    t_out_item         n_out;

    // Clamp the slot count to 1 .. TABLE_DEPTH
    always_comb begin
        if (r_slots == '0) begin
            slot_n = CNT_W'(1);
        end else if (PRB_W'(r_slots) > DEPTH_N) begin
            slot_n = CNT_W'(DEPTH_N);
        end else begin
            slot_n = r_slots;
        end
    end

    assign lk_limit = !r_hash_mode ? CNT_W'(1) :
                      (r_max_probe < slot_n) ? r_max_probe : slot_n;
    assign need_sum = r_new_total + SUM_W'(r_base);
    assign ins_off  = OFF_W'(SUM_W'(0) - need_sum);
    assign rd_off   = r_rd[OFF_W-1:0];

    otlp_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mod_start),
        .i_value (r_key >> r_id_shift),
        .i_div   (slot_n),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_mode <= 1'b0;
            r_id_shift  <= '0;
            r_slots     <= SLOTS_RESET;
            r_base      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg.addr)
                REG_HASH_MODE: r_hash_mode <= i_cfg.wdata[0];
                REG_ID_SHIFT:  r_id_shift  <= i_cfg.wdata[SHIFT_W-1:0];
                REG_SLOTS:     r_slots     <= i_cfg.wdata[SLOTS_W-1:0];
                REG_BASE:      r_base      <= i_cfg.wdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_item.op;
            r_key       <= i_item.key_id;
            r_order     <= i_item.slot_order;
            r_tag       <= i_item.type_tag;
            r_obj       <= i_item.obj_address;
            r_new_total <= SUM_W'(r_size_total) + SUM_W'(i_item.ext_size);
        end
    end

    // Probe position and probe count
    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_order) begin
            r_pos <= IDX_W'(r_order);
        end else if (i_cmd.pos_mod) begin
            r_pos <= IDX_W'(mod_rem);
        end else if (i_cmd.advance) begin
            if (PRB_W'(r_pos) + PRB_W'(1) == PRB_W'(slot_n)) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + IDX_W'(1);
            end
        end
        if (i_cmd.load) begin
            r_probes <= '0;
        end else if (i_cmd.count) begin
            r_probes <= r_probes + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            mem[r_pos] <= {r_tag, ins_off};
        end
        if (i_cmd.read) begin
            r_rd       <= mem[r_pos];
            r_rd_valid <= r_valid[r_pos];
        end
    end

    always_comb begin
        n_size_total = r_size_total;
        n_max_probe  = r_max_probe;
        if (i_cmd.clear) begin
            n_size_total = '0;
            n_max_probe  = CNT_W'(1);
        end else if (i_cmd.commit) begin
            n_size_total = r_new_total[TOT_W-1:0];
            if (r_hash_mode && r_probes > r_max_probe) begin
                n_max_probe = r_probes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_size_total <= '0;
            r_max_probe  <= CNT_W'(1);
        end else begin
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (i_cmd.commit) begin
                r_valid[r_pos] <= 1'b1;
            end
            r_size_total <= n_size_total;
            r_max_probe  <= n_max_probe;
        end
    end

    // Result assembly
    always_comb begin
        n_out               = '0;
        n_out.status        = i_cmd.res_status;
        n_out.probes        = PRB_W'(r_probes);
        n_out.total_size    = n_size_total;
        n_out.search_length = SRCH_W'(n_max_probe);
        unique case (i_cmd.res_kind)
            KIND_HIT: begin
                n_out.offset  = rd_off;
                n_out.address = r_obj + {{(ADDR_W-OFF_W){rd_off[OFF_W-1]}}, rd_off};
            end
            KIND_INS: n_out.offset = ins_off;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.hash_mode = r_hash_mode;
    assign o_sts.order_ok  = PRB_W'(r_order) < PRB_W'(slot_n);
    assign o_sts.mod_done  = mod_done;
    assign o_sts.slot_free = !r_valid[r_pos];
    assign o_sts.tag_match = r_rd_valid && (r_rd[TAG_W+OFF_W-1:OFF_W] == r_tag);
    assign o_sts.ins_last  = (r_probes + CNT_W'(1)) == slot_n;
    assign o_sts.lk_last   = r_probes == lk_limit;
    assign o_sts.overflow  = need_sum[SUM_W-1];
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_finish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken item");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_valid == '0 && r_size_total == '0))
        else $error("clear left occupied slots or size");
    a_max_probe_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_probe != '0)
        else $error("longest probe dropped to zero");
`endif

endmodule

// ===== sv/otlp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences decode, remainder, probing, commit, clear and result load.
// Depends on otlp_pkg; talks to otlp_dp through t_dp_cmd and t_dp_sts.
module otlp_ctrl import otlp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_MOD     = 4'd2;
    localparam logic [3:0] S_INS_CHK = 4'd3;
    localparam logic [3:0] S_LK_RD   = 4'd4;
    localparam logic [3:0] S_LK_CHK  = 4'd5;
    localparam logic [3:0] S_COMMIT  = 4'd6;
    localparam logic [3:0] S_CLEAR   = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [STAT_W-1:0] r_code, n_code;
    logic [KIND_W-1:0] r_kind, n_kind;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // Take nothing while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_sts.op)
                    OP_CLEAR: n_state = S_CLEAR;
                    OP_NONE: begin
                        n_code  = ST_OK;
                        n_kind  = KIND_NONE;
                        n_state = S_FIN;
                    end
                    OP_INSERT, OP_LOOKUP: begin
                        priority if (i_sts.hash_mode) begin
                            o_cmd.mod_start = 1'b1;
                            n_state = S_MOD;
                        end else if (!i_sts.order_ok) begin
                            n_code  = ST_RANGE;
                            n_kind  = KIND_NONE;
                            n_state = S_FIN;
                        end else if (i_sts.op == OP_INSERT) begin
                            o_cmd.pos_order = 1'b1;
                            o_cmd.count     = 1'b1;
                            n_state = S_COMMIT;
                        end else begin
                            o_cmd.pos_order = 1'b1;
                            n_state = S_LK_RD;
                        end
                    end
                endcase
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.pos_mod = 1'b1;
                    n_state = (i_sts.op == OP_INSERT) ? S_INS_CHK : S_LK_RD;
                end
            end
            S_INS_CHK: begin
                o_cmd.count = 1'b1;
                priority if (i_sts.slot_free) begin
                    n_state = S_COMMIT;
                end else if (i_sts.ins_last) begin
                    n_code  = ST_FULL;
                    n_kind  = KIND_NONE;
                    n_state = S_FIN;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_LK_RD: begin
                o_cmd.read  = 1'b1;
                o_cmd.count = 1'b1;
                n_state = S_LK_CHK;
            end
            S_LK_CHK: begin
                priority if (i_sts.tag_match) begin
                    n_code  = ST_OK;
                    n_kind  = KIND_HIT;
                    n_state = S_FIN;
                end else if (i_sts.lk_last) begin
                    n_code  = ST_NOTFOUND;
                    n_kind  = KIND_NONE;
                    n_state = S_FIN;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_LK_RD;
                end
            end
            S_COMMIT: begin
                // Store and report in the same cycle, so wait for room first
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    if (i_sts.overflow) begin
                        o_cmd.res_status = ST_OVERFLOW;
                        o_cmd.res_kind   = KIND_NONE;
                    end else begin
                        o_cmd.commit     = 1'b1;
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_kind   = KIND_INS;
                    end
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (i_sts.out_free) begin
                    o_cmd.clear      = 1'b1;
                    o_cmd.finish     = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_kind   = KIND_NONE;
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.res_status = r_code;
                    o_cmd.res_kind   = r_kind;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_kind <= n_kind;
    end

`ifndef ASSERT_OFF
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DEC))
        else $error("accepted item not decoded");
    a_commit_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!i_sts.overflow && o_cmd.finish))
        else $error("insert stored without a clean result");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("input taken outside idle");
`endif

endmodule

// ===== sv/offset_table_linear_probe.sv =====
`timescale 1ns / 1ps
// Offset table with linear probing; one item in work, input taken only in idle.
// Clear, unused op, range error: decode, load result. Ordered insert: decode, commit.
// Ordered lookup: decode, read, check. Hash ops form the home slot in the remainder
// unit, then check each insert probe, or read and check each lookup probe. Next item
// taken in the cycle after the result loads; an untaken result stalls the last step.
// Sync active-low reset empties the table, zeroes size, sets longest probe to 1.
module offset_table_linear_probe import otlp_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    otlp_chan_if.sink     i_in,
    otlp_chan_if.source   o_out,
    otlp_chan_if.sink     i_cfg
);

    t_dp_cmd   cmd;
    t_dp_sts   sts;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = i_rst_n;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_item;

    otlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    otlp_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in.data),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg       (i_cfg.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (out_item)
    );

endmodule

// ===== tb/offset_table_linear_probe_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for offset_table_linear_probe: random and directed table ops.
// Depends on otlp_pkg and otlp_chan_if; predicts each result and checks it in order.
module offset_table_linear_probe_test;
    import otlp_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int KNOWN_MAX   = 24;

    logic i_clk;
    logic i_rst_n;

    otlp_chan_if #(.t_payload(t_in_item))  in_ch  ();
    otlp_chan_if #(.t_payload(t_out_item)) out_ch ();
    otlp_chan_if #(.t_payload(t_cfg_item)) cfg_ch ();

    offset_table_linear_probe #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow of the table and its registers
    logic [TAG_W-1:0]  slot_tag  [TABLE_DEPTH];
    logic [OFF_W-1:0]  slot_off  [TABLE_DEPTH];
    bit                slot_used [TABLE_DEPTH];
    logic [TOT_W-1:0]  run_total;
    logic [SRCH_W-1:0] longest;
    logic              cfg_hash;
    logic [SHIFT_W-1:0] cfg_shift;
    logic [SLOTS_W-1:0] cfg_slots;
    logic [BASE_W-1:0]  cfg_base;

    t_in_item  pending_items[$];
    t_cfg_item reg_writes[$];
    t_out_item predicted_replies[$];

    // What the stimulus has put in the table, for lookups that should hit
    logic [KEY_W-1:0] known_keys[$];
    logic [ORD_W-1:0] known_slots[$];
    logic [TAG_W-1:0] known_tags[$];

    bit          calm;
    int unsigned in_wait;
    int unsigned out_hold;
    int unsigned quiet_cycles;
    int unsigned replies_seen;
    int unsigned mismatch_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned slot_limit();
        if (cfg_slots == 0) return 1;
        if (cfg_slots > TABLE_DEPTH) return TABLE_DEPTH;
        return cfg_slots;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Work out the result of one op and update the shadow table
    function automatic t_out_item probe_table(t_in_item it);
        t_out_item       r;
        int unsigned     n, p, pos, lim;
        longint unsigned total;
        bit              found;
        r     = '0;
        n     = slot_limit();
        pos   = 0;
        found = 1'b0;
        case (it.op)
            OP_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
                run_total = '0;
                longest   = SRCH_W'(1);
            end
            OP_INSERT: begin
                if (!cfg_hash) begin
                    if (it.slot_order >= n) begin
                        r.status = ST_RANGE;
                    end else begin
                        pos      = it.slot_order;
                        r.probes = PRB_W'(1);
                        found    = 1'b1;
                    end
                end else begin
                    p = (it.key_id >> cfg_shift) % n;
                    for (int i = 0; i < n && !found; i++) begin
                        r.probes = r.probes + 1'b1;
                        if (!slot_used[p]) begin
                            pos   = p;
                            found = 1'b1;
                        end else begin
                            p = (p + 1) % n;
                        end
                    end
                    if (!found) r.status = ST_FULL;
                end
                if (found) begin
                    total = run_total + it.ext_size;
                    if (total + cfg_base > 64'h7FFF_FFFF) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        run_total      = total[TOT_W-1:0];
                        r.offset       = OFF_W'(-(total + cfg_base));
                        slot_tag[pos]  = it.type_tag;
                        slot_off[pos]  = r.offset;
                        slot_used[pos] = 1'b1;
                        if (cfg_hash && r.probes > longest) longest = r.probes;
                    end
                end
            end
            OP_LOOKUP: begin
                if (!cfg_hash) begin
                    if (it.slot_order >= n) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.probes = PRB_W'(1);
                        pos      = it.slot_order;
                        found    = slot_used[pos] && slot_tag[pos] == it.type_tag;
                    end
                end else begin
                    lim = (longest < n) ? longest : n;
                    p   = (it.key_id >> cfg_shift) % n;
                    for (int i = 0; i < lim && !found; i++) begin
                        r.probes = r.probes + 1'b1;
                        if (slot_used[p] && slot_tag[p] == it.type_tag) begin
                            pos   = p;
                            found = 1'b1;
                        end else begin
                            p = (p + 1) % n;
                        end
                    end
                end
                if (found) begin
                    r.offset  = slot_off[pos];
                    r.address = it.obj_address + {{32{slot_off[pos][OFF_W-1]}}, slot_off[pos]};
                end else if (r.status == ST_OK) begin
                    r.status = ST_NOTFOUND;
                end
            end
            default: ;
        endcase
        r.total_size    = run_total;
        r.search_length = longest;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("result %0d: %s got %0h want %0h", replies_seen, what, got, want);
    endtask

    task automatic check_reply(t_out_item got, t_out_item want);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.offset !== want.offset)
            report_mismatch("offset", got.offset, want.offset);
        if (got.address !== want.address)
            report_mismatch("address", got.address, want.address);
        if (got.probes !== want.probes)
            report_mismatch("probes", got.probes, want.probes);
        if (got.total_size !== want.total_size)
            report_mismatch("total_size", got.total_size, want.total_size);
        if (got.search_length !== want.search_length)
            report_mismatch("search_length", got.search_length, want.search_length);
    endtask

    // Input driver: predict at acceptance, then hold off for a random gap
    always @(posedge i_clk) begin : feed_items
        bit take_next;
        take_next = 1'b0;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_wait = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_tag[i]  = '0;
                slot_off[i]  = '0;
                slot_used[i] = 1'b0;
            end
            run_total = '0;
            longest   = SRCH_W'(1);
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predicted_replies.push_back(probe_table(in_ch.data));
                in_wait = pick_gap();
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (in_wait > 0) in_wait--;
                else if (pending_items.size() > 0) take_next = 1'b1;
            end
            if (take_next) begin
                in_ch.data  <= pending_items.pop_front();
                in_ch.valid <= 1'b1;
            end else if (!in_ch.valid || in_ch.ready) begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin : check_results
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_hold = 0;
            replies_seen   = 0;
            mismatch_count = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                replies_seen++;
                if (predicted_replies.size() == 0)
                    report_mismatch("item with none expected", out_ch.data.status, '0);
                else
                    check_reply(out_ch.data, predicted_replies.pop_front());
                out_hold = pick_gap();
            end else if (out_hold == 0 && $urandom_range(7) == 0) begin
                out_hold = pick_gap();
            end
            if (out_hold > 0) begin
                out_hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : write_regs
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_hash  = 1'b0;
            cfg_shift = '0;
            cfg_slots = SLOTS_RESET;
            cfg_base  = '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.data.addr)
                    REG_HASH_MODE: cfg_hash  = cfg_ch.data.wdata[0];
                    REG_ID_SHIFT:  cfg_shift = cfg_ch.data.wdata[SHIFT_W-1:0];
                    REG_SLOTS:     cfg_slots = cfg_ch.data.wdata[SLOTS_W-1:0];
                    REG_BASE:      cfg_base  = cfg_ch.data.wdata[BASE_W-1:0];
                    default: ;
                endcase
            end
            if (!cfg_ch.valid || cfg_ch.ready) begin
                if (reg_writes.size() > 0) begin
                    cfg_ch.data  <= reg_writes.pop_front();
                    cfg_ch.valid <= 1'b1;
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic t_in_item mk_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                         logic [ORD_W-1:0] ord, logic [TAG_W-1:0] tag,
                                         logic [EXT_W-1:0] ext, logic [ADDR_W-1:0] obj);
        t_in_item it;
        it.op          = op;
        it.key_id      = key;
        it.slot_order  = ord;
        it.type_tag    = tag;
        it.ext_size    = ext;
        it.obj_address = obj;
        return it;
    endfunction

    // Wait until every item and register write is through and every result is in
    task automatic settle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || in_ch.valid || predicted_replies.size() != 0
               || reg_writes.size() != 0 || cfg_ch.valid);
    endtask

    task automatic set_config(logic hash, logic [SHIFT_W-1:0] shift,
                              logic [SLOTS_W-1:0] slots, logic [BASE_W-1:0] base);
        settle();
        reg_writes.push_back('{addr: REG_HASH_MODE, wdata: CFG_DATA_W'(hash)});
        reg_writes.push_back('{addr: REG_ID_SHIFT,  wdata: CFG_DATA_W'(shift)});
        reg_writes.push_back('{addr: REG_SLOTS,     wdata: CFG_DATA_W'(slots)});
        reg_writes.push_back('{addr: REG_BASE,      wdata: CFG_DATA_W'(base)});
        settle();
    endtask

    task automatic forget_known();
        known_keys.delete();
        known_slots.delete();
        known_tags.delete();
    endtask

    task automatic run_random(int unsigned count);
        t_in_item    it;
        int unsigned n, roll, k;
        n = slot_limit();
        for (int unsigned i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            it = mk_item(OP_INSERT, $urandom, ORD_W'($urandom_range(n - 1)),
                         {$urandom, $urandom},
                         ($urandom_range(6) == 0) ? EXT_W'($urandom)
                                                  : EXT_W'($urandom_range(255)),
                         {$urandom, $urandom});
            if (roll < 4) begin
                it.op = OP_CLEAR;
                forget_known();
            end else if (roll < 6) begin
                it.op = OP_NONE;
            end else if (roll < 10) begin
                // noise: any op, any slot
                it.op         = OP_W'($urandom_range(3));
                it.slot_order = ORD_W'($urandom_range(255));
            end else if (roll < 52) begin
                known_keys.push_back(it.key_id);
                known_slots.push_back(it.slot_order);
                known_tags.push_back(it.type_tag);
                if (known_tags.size() > KNOWN_MAX) begin
                    void'(known_keys.pop_front());
                    void'(known_slots.pop_front());
                    void'(known_tags.pop_front());
                end
            end else begin
                it.op = OP_LOOKUP;
                if (known_tags.size() > 0 && $urandom_range(4) != 0) begin
                    k             = $urandom_range(known_tags.size() - 1);
                    it.key_id     = known_keys[k];
                    it.slot_order = known_slots[k];
                    it.type_tag   = known_tags[k];
                end
            end
            pending_items.push_back(it);
        end
    endtask

    // Pile up large extensions until the running size overflows
    task automatic run_size_burst();
        int unsigned n;
        n = slot_limit();
        forget_known();
        pending_items.push_back(mk_item(OP_CLEAR, '0, '0, '0, '0, '0));
        for (int i = 0; i < 150; i++)
            pending_items.push_back(mk_item(OP_INSERT, $urandom,
                                            ORD_W'($urandom_range(n - 1)),
                                            {$urandom, $urandom},
                                            EXT_W'($urandom_range(24'hF00000, 24'hFFFFFF)),
                                            {$urandom, $urandom}));
    endtask

    initial begin : run_test
        logic [TAG_W-1:0] tag_a, tag_b, tag_c;
        i_rst_n      = 1'b0;
        calm         = 1'b0;
        tag_a = 64'h0123_4567_89AB_CDEF;
        tag_b = 64'hFEDC_BA98_7654_3210;
        tag_c = 64'h8000_0000_0000_0001;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Ordered table at reset settings: empty miss, tag zero, extremes, range, overwrite
        pending_items.push_back(mk_item(OP_LOOKUP, '0, 8'd0, '0, '0, '0));
        pending_items.push_back(mk_item(OP_INSERT, '0, 8'd0, '0, '0, '0));
        pending_items.push_back(mk_item(OP_LOOKUP, '0, 8'd0, '0, '0, '1));
        pending_items.push_back(mk_item(OP_INSERT, '1, 8'd15, '1, '1, '1));
        pending_items.push_back(mk_item(OP_LOOKUP, '1, 8'd15, '1, '1, '0));
        pending_items.push_back(mk_item(OP_INSERT, '0, 8'd16, tag_a, 24'd5, '0));
        pending_items.push_back(mk_item(OP_LOOKUP, '0, 8'd255, '1, '0, '1));
        pending_items.push_back(mk_item(OP_INSERT, '0, 8'd15, tag_b, 24'd7, '0));
        pending_items.push_back(mk_item(OP_LOOKUP, '0, 8'd15, '1, '0, 64'h1000));
        pending_items.push_back(mk_item(OP_NONE, '1, '1, '1, '1, '1));
        pending_items.push_back(mk_item(OP_CLEAR, '0, '0, '0, '0, '0));

        // Hash table of four slots: collisions, duplicate tag, full, wrap-around probe
        set_config(1'b1, 4'd15, 5'd4, 6'd32);
        pending_items.push_back(mk_item(OP_INSERT, '0, '0, tag_a, 24'd1, '0));
        pending_items.push_back(mk_item(OP_INSERT, '0, '0, tag_b, 24'd2, '0));
        pending_items.push_back(mk_item(OP_INSERT, '0, '0, tag_a, 24'd3, '0));
        pending_items.push_back(mk_item(OP_INSERT, '0, '0, tag_c, 24'd4, '0));
        pending_items.push_back(mk_item(OP_INSERT, '0, '0, 64'd99, 24'd5, '0));
        pending_items.push_back(mk_item(OP_LOOKUP, '0, '0, tag_a, '0, 64'h8000));
        pending_items.push_back(mk_item(OP_LOOKUP, '0, '0, tag_c, '0, 64'h8000));
        pending_items.push_back(mk_item(OP_LOOKUP, 32'h0001_8000, '0, tag_b, '0, '1));
        pending_items.push_back(mk_item(OP_LOOKUP, '0, '0, 64'd77, '0, '1));
        pending_items.push_back(mk_item(OP_CLEAR, '0, '0, '0, '0, '0));
        pending_items.push_back(mk_item(OP_LOOKUP, '0, '0, tag_a, '0, '1));

        // Slot count zero behaves as one slot
        set_config(1'b1, 4'd0, 5'd0, 6'd0);
        pending_items.push_back(mk_item(OP_INSERT, '1, '0, 64'd9, 24'd3, '0));
        pending_items.push_back(mk_item(OP_INSERT, '1, '0, 64'd10, 24'd3, '0));
        pending_items.push_back(mk_item(OP_LOOKUP, '1, '0, 64'd9, '0, 64'd100));

        set_config(1'b1, 4'd0, 5'd16, 6'd0);
        run_random(250);
        set_config(1'b0, 4'd15, 5'd16, 6'd32);
        calm = 1'b1;
        run_size_burst();
        run_random(200);
        set_config(1'b1, 4'd15, 5'd1, 6'd32);
        calm = 1'b0;
        run_random(200);
        set_config(1'b1, 4'd4, 5'd5, 6'd17);
        run_random(250);
        set_config(1'b0, 4'd0, 5'd1, 6'd0);
        calm = 1'b1;
        run_random(200);
        set_config(1'b1, SHIFT_W'($urandom_range(15)), 5'd0, BASE_W'($urandom_range(32)));
        calm = 1'b0;
        run_random(150);
        set_config(1'b1, SHIFT_W'($urandom_range(15)), 5'd31, BASE_W'($urandom_range(32)));
        run_random(250);
        for (int ph = 0; ph < 2; ph++) begin
            set_config(1'($urandom_range(1)), SHIFT_W'($urandom_range(15)),
                       SLOTS_W'($urandom_range(1, 16)), BASE_W'($urandom_range(32)));
            run_random(175);
        end

        settle();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
